### hdl/ostt_pkg.sv
// Shared types and constants of the one-shot timer table.
package ostt_pkg;

    // Input action codes.
    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_START = 2'd1;
    localparam logic [1:0] ACT_STOP  = 2'd2;

    // Result kind codes.
    localparam logic [1:0] KIND_DONE      = 2'd0;
    localparam logic [1:0] KIND_FULL      = 2'd1;
    localparam logic [1:0] KIND_EXPIRED   = 2'd2;
    localparam logic [1:0] KIND_IDLE_TICK = 2'd3;

    // Tick period and rounding term of the millisecond to tick conversion.
    localparam int unsigned TICK_ROUND = 49;
    localparam int unsigned TICK_MS    = 50;

    // Width of a remaining tick count.
    localparam int REM_W = 27;

    // The divider retires DIV_BITS quotient bits per cycle over a padded dividend.
    localparam int DIV_BITS  = 4;
    localparam int DIV_STEPS = 9;
    localparam int DIV_W     = DIV_BITS * DIV_STEPS;
    localparam int DREM_W    = 6;

    // Most expiry results reported for one tick.
    localparam int MAX_RES = 8;

    typedef enum logic [1:0] {
        OP_TICK,
        OP_START,
        OP_STOP,
        OP_NOP
    } t_op;

    typedef struct packed {
        logic [1:0]         action;
        logic [7:0]         owner_id;
        logic signed [15:0] depth;
        logic [15:0]        event_id;
        logic [31:0]        timeout_ms;
    } t_in;

    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         owner_id_out;
        logic signed [15:0] depth_out;
        logic [15:0]        event_id_out;
        logic [2:0]         slot;
        logic               last;
    } t_res;

    // Classified command passed from the front end to the slot engine.
    typedef struct packed {
        t_op                op;
        logic [7:0]         owner_id;
        logic signed [15:0] depth;
        logic [15:0]        event_id;
        logic [REM_W-1:0]   ticks;
    } t_cmd;

endpackage

### hdl/ostt_fifo.sv
// Two-entry queue used between the front end, the slot engine and the result port.
module ostt_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;
    logic             n_wp;
    logic             n_rp;
    logic [1:0]       n_cnt;
    logic             wr;
    logic             rd;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;

    always_comb begin
        n_wp  = wr ? ~r_wp : r_wp;
        n_rp  = rd ? ~r_rp : r_rp;
        n_cnt = r_cnt;
        if (wr && !rd) begin
            n_cnt = r_cnt + 2'd1;
        end else if (rd && !wr) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

### hdl/ostt_front.sv
// Front end: accepts input items, classifies them and converts timeouts to ticks.
module ostt_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ostt_pkg::t_in   i_item,
    output logic            o_full,
    output ostt_pkg::t_cmd  o_cmd,
    output logic            o_cmd_push,
    input  logic            i_cmd_full
);
    import ostt_pkg::*;

    logic              r_busy;
    t_cmd              r_cmd;
    logic [DIV_W-1:0]  r_div;
    logic [DREM_W-1:0] r_rem;
    logic [REM_W-1:0]  r_quo;
    logic [3:0]        r_steps;

    logic              accept;
    logic              done;
    t_op               op;
    logic [DREM_W-1:0] n_rem;
    logic [DIV_BITS-1:0] qd;

    assign done       = r_busy && (r_steps == 4'd0);
    assign o_cmd_push = done && !i_cmd_full;
    assign o_full     = r_busy && !o_cmd_push;
    assign accept     = i_push && !o_full;

    always_comb begin
        unique case (i_item.action)
            ACT_TICK:  op = OP_TICK;
            ACT_START: op = OP_START;
            ACT_STOP:  op = OP_STOP;
            default:   op = OP_NOP;
        endcase
    end

    // Four restoring steps per cycle; the partial remainder stays below 50.
    always_comb begin
        logic [DREM_W:0] t;
        n_rem = r_rem;
        qd    = '0;
        for (int j = 0; j < DIV_BITS; j++) begin
            t = {n_rem, r_div[DIV_W-1-j]};
            if (t >= (DREM_W+1)'(TICK_MS)) begin
                t = t - (DREM_W+1)'(TICK_MS);
                qd[DIV_BITS-1-j] = 1'b1;
            end
            n_rem = t[DREM_W-1:0];
        end
    end

    always_comb begin
        o_cmd = r_cmd;
        o_cmd.ticks = (r_quo == '0) ? REM_W'(1) : r_quo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_steps <= 4'd0;
        end else begin
            if (accept) begin
                r_busy  <= 1'b1;
                r_steps <= (op == OP_START) ? 4'(DIV_STEPS) : 4'd0;
            end else if (o_cmd_push) begin
                r_busy <= 1'b0;
            end else if (r_busy && r_steps != 4'd0) begin
                r_steps <= r_steps - 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd.op       <= op;
            r_cmd.owner_id <= i_item.owner_id;
            r_cmd.depth    <= i_item.depth;
            r_cmd.event_id <= i_item.event_id;
            r_cmd.ticks    <= '0;
            r_div <= DIV_W'({1'b0, i_item.timeout_ms} + 33'(TICK_ROUND));
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy && r_steps != 4'd0) begin
            r_div <= {r_div[DIV_W-DIV_BITS-1:0], {DIV_BITS{1'b0}}};
            r_rem <= n_rem;
            r_quo <= {r_quo[REM_W-DIV_BITS-1:0], qd};
        end
    end

endmodule

### hdl/ostt_back.sv
// Slot engine: scans the timer slots in order and carries out one command at a time.
module ostt_back #(
    parameter int SLOTS = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ostt_pkg::t_cmd  i_cmd,
    input  logic            i_cmd_empty,
    output logic            o_cmd_pop,
    output ostt_pkg::t_res  o_res,
    output logic            o_res_push,
    input  logic            i_res_full
);
    import ostt_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } t_state;

    typedef struct packed {
        logic [7:0]         owner;
        logic signed [15:0] depth;
        logic [15:0]        evt;
        logic [REM_W-1:0]   rem;
    } t_slot;

    t_state           r_state;
    t_cmd             r_cmd;
    logic [SLOTS-1:0] r_active;
    t_slot            r_mem [SLOTS];
    t_slot            r_rd_data;
    logic [CW-1:0]    r_rd_cnt;
    logic             r_ev_vld;
    logic [IW-1:0]    r_ev_idx;
    t_res             r_pend;
    logic             r_have;
    logic [3:0]       r_nexp;

    logic             ev_act;
    logic             match;
    logic [REM_W-1:0] dec;
    logic             ev_last;
    logic             expiry;
    logic             emit;
    logic             stall;
    logic             consume;
    logic             start_hit;
    logic             scan_done;
    logic             issue;
    logic [IW-1:0]    rd_addr;
    logic             wr_en;
    t_slot            wr_data;
    logic [IW+2:0]    slot_ext;
    t_res             final_res;

    assign ev_act    = r_active[r_ev_idx];
    assign match     = (r_rd_data.owner == r_cmd.owner_id) && (r_rd_data.depth == r_cmd.depth);
    assign dec       = (r_rd_data.rem == '0) ? '0 : r_rd_data.rem - REM_W'(1);
    assign ev_last   = (r_ev_idx == IW'(SLOTS - 1));
    assign expiry    = (r_cmd.op == OP_TICK) && ev_act && (dec == '0);
    assign emit      = expiry && (r_nexp < 4'(MAX_RES));
    // A new expiry pushes the one held back, which is then known not to be last.
    assign stall     = emit && r_have && i_res_full;
    assign consume   = (r_state == ST_SCAN) && r_ev_vld && !stall;
    assign start_hit = (r_cmd.op == OP_START) && (!ev_act || match);
    assign scan_done = consume && (ev_last || start_hit);
    assign issue     = (r_state == ST_SCAN) && (r_rd_cnt < CW'(SLOTS))
                       && (!r_ev_vld || consume) && !scan_done;
    assign rd_addr   = r_rd_cnt[IW-1:0];
    assign slot_ext  = {3'b000, r_ev_idx};
    assign o_cmd_pop = (r_state == ST_IDLE) && !i_cmd_empty;

    always_comb begin
        wr_en   = 1'b0;
        wr_data = r_rd_data;
        if (consume) begin
            if (r_cmd.op == OP_TICK && ev_act && dec != '0) begin
                wr_en       = 1'b1;
                wr_data.rem = dec;
            end else if (start_hit) begin
                wr_en         = 1'b1;
                wr_data.owner = r_cmd.owner_id;
                wr_data.depth = r_cmd.depth;
                wr_data.evt   = r_cmd.event_id;
                wr_data.rem   = r_cmd.ticks;
            end
        end
    end

    always_comb begin
        final_res      = r_pend;
        final_res.last = 1'b1;
        if (r_cmd.op == OP_TICK && !r_have) begin
            final_res      = '0;
            final_res.kind = KIND_IDLE_TICK;
            final_res.last = 1'b1;
        end
    end

    always_comb begin
        if (r_state == ST_FINISH) begin
            o_res      = final_res;
            o_res_push = !i_res_full;
        end else begin
            o_res      = r_pend;
            o_res_push = consume && emit && r_have;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_active <= '0;
            r_rd_cnt <= '0;
            r_ev_vld <= 1'b0;
            r_have   <= 1'b0;
            r_nexp   <= 4'd0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (!i_cmd_empty) begin
                        r_rd_cnt <= '0;
                        r_ev_vld <= 1'b0;
                        r_have   <= 1'b0;
                        r_nexp   <= 4'd0;
                        r_state  <= (i_cmd.op == OP_NOP) ? ST_FINISH : ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (issue) begin
                        r_rd_cnt <= r_rd_cnt + CW'(1);
                        r_ev_vld <= 1'b1;
                    end else if (consume) begin
                        r_ev_vld <= 1'b0;
                    end
                    if (consume) begin
                        if (expiry || (r_cmd.op == OP_STOP && ev_act && match)) begin
                            r_active[r_ev_idx] <= 1'b0;
                        end else if (start_hit) begin
                            r_active[r_ev_idx] <= 1'b1;
                        end
                        if (emit) begin
                            r_have <= 1'b1;
                            r_nexp <= r_nexp + 4'd1;
                        end
                    end
                    if (scan_done) begin
                        r_state <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (!i_res_full) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd  <= i_cmd;
            r_pend <= '0;
        end else if (consume) begin
            if (emit) begin
                r_pend.kind         <= KIND_EXPIRED;
                r_pend.owner_id_out <= r_rd_data.owner;
                r_pend.depth_out    <= r_rd_data.depth;
                r_pend.event_id_out <= r_rd_data.evt;
                r_pend.slot         <= slot_ext[2:0];
                r_pend.last         <= 1'b0;
            end else if (start_hit) begin
                r_pend <= {KIND_DONE, 8'd0, 16'd0, 16'd0, slot_ext[2:0], 1'b0};
            end else if (r_cmd.op == OP_START && ev_last) begin
                r_pend <= {KIND_FULL, 8'd0, 16'd0, 16'd0, 3'd0, 1'b0};
            end
        end
        if (issue) begin
            r_ev_idx <= rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_ev_idx] <= wr_data;
        end
        if (issue) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

endmodule

### hdl/one_shot_timer_table.sv
// Top level of the one-shot timer table: front end, command queue, slot engine, result queue.
//
// A table of SLOTS one-shot timers driven through two queue-style ports. Each input item
// (tick, start or stop) produces one result, except a tick that expires several timers,
// which produces one expiry result per timer, for at most MAX_RES timers, in slot order,
// with last set on the final one. The front end turns a start's timeout into ticks with a
// divider that retires four quotient bits per cycle; ticks and stops skip the divider.
// The slot engine then walks the slot memory one slot per cycle through its single read
// port, stalling while a held expiry result meets a full result queue; a start ends the
// walk at the slot it takes. The front end works on the next item while the engine is
// busy, and a two-entry queue sits between them.
module one_shot_timer_table #(
    parameter int SLOTS = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            push,
    output logic            full,
    input  ostt_pkg::t_in   i_item,
    output logic            empty,
    input  logic            pop,
    output ostt_pkg::t_res  o_result
);
    import ostt_pkg::*;

    t_cmd front_cmd;
    logic front_push;
    logic cmd_full;
    t_cmd cmd_head;
    logic cmd_empty;
    logic cmd_pop;
    t_res back_res;
    logic res_push;
    logic res_full;

    ostt_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_item     (i_item),
        .o_full     (full),
        .o_cmd      (front_cmd),
        .o_cmd_push (front_push),
        .i_cmd_full (cmd_full)
    );

    ostt_fifo #(
        .WIDTH ($bits(t_cmd))
    ) u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_data  (front_cmd),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_data  (cmd_head),
        .o_empty (cmd_empty)
    );

    ostt_back #(
        .SLOTS (SLOTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd_head),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .o_res       (back_res),
        .o_res_push  (res_push),
        .i_res_full  (res_full)
    );

    ostt_fifo #(
        .WIDTH ($bits(t_res))
    ) u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (back_res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (o_result),
        .o_empty (empty)
    );

    a_cmd_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_pop |-> !cmd_empty)
        else $error("command queue popped while empty");

    a_res_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> !res_full)
        else $error("result pushed into a full result queue");

    a_full_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.kind == KIND_FULL) |-> (o_result.last && o_result.slot == 3'd0))
        else $error("table full result is not a single final result");

    a_idle_tick_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.kind == KIND_IDLE_TICK)
        |-> (o_result.last && o_result.owner_id_out == 8'd0 && o_result.event_id_out == 16'd0))
        else $error("tick without expiry carries stale fields");

endmodule
